// File: hdl/assert_macros.svh
// Assertion macros shared by the stepper ramp controller RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high
`define SRMC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also holds across reset
`define SRMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// File: hdl/srmc_pkg.sv
// Shared types, codes and constants for the stepper ramp move controller.
// No dependencies.
package srmc_pkg;

   // Default ramp table depth
   localparam int TABLE_LENGTH_DEFAULT = 64;

   // Timer period before the first step pulse loads one from the ramp table
   localparam logic [15:0] PERIOD_RESET = 16'(16000000 / 64 / 61 - 1);

   // Configuration port geometry and register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_PAUSE   = 1'd1;

   // Reset values of the configuration registers
   localparam logic [6:0]  SPEED_LIMIT_RESET = 7'd100;
   localparam logic [15:0] DIR_PAUSE_RESET   = 16'd100;

   // Reciprocal of 100 in 2^-19 units; exact for numerators below 43690
   localparam int RECIP_100     = 5243;
   localparam int RECIP_100_SHR = 19;

   typedef enum logic [2:0] {
      CMD_POLL     = 3'd0,
      CMD_MOVE     = 3'd1,
      CMD_EXTEND   = 3'd2,
      CMD_STOP     = 3'd3,
      CMD_TURN_OFF = 3'd4,
      CMD_STEP     = 3'd5,
      CMD_MS_TICK  = 3'd6,
      CMD_LOAD     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OFF  = 2'd0,
      ST_RUN  = 2'd1,
      ST_WAIT = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_MOVE   = 2'd1,
      EV_EXTEND = 2'd2,
      EV_OFF    = 2'd3
   } event_type;

   // One result word, less the timer period (which comes from the ramp RAM)
   typedef struct packed {
      state_type   machine_state;
      logic        sleep_level;
      logic        microstep_level;
      logic        direction_level;
      logic        step_pulse;
      logic [5:0]  speed_index;
      logic        stopped;
      logic [31:0] steps_this_move;
   } result_type;

   // Ramp index cap: percent * top_index / 100, truncated, saturated at top_index
   function automatic logic [31:0] cap_calc(input logic [6:0] percent, input int top_index);
      logic [31:0] prod;
      logic [31:0] quot;
      prod = 32'(percent) * 32'(top_index * RECIP_100);
      quot = prod >> RECIP_100_SHR;
      if (quot > 32'(top_index)) begin
         quot = 32'(top_index);
      end
      return quot;
   endfunction

endpackage

// File: hdl/stepper_ramp_move_controller_top.sv
// Top level of the stepper ramp move controller: handshakes, config and ramp RAM.
// Depends on srmc_pkg, srmc_ram, srmc_core and assert_macros.svh.
//
// Usage:
//   req_* carries one command word (poll, move, extend, stop, turn-off, step tick,
//   millisecond tick, ramp table load). Every command word yields exactly one rsp_*
//   word with the machine state, pin levels, step pulse, timer period, ramp index and
//   step counts after that command.
//   A word is taken when valid is high and stall is low, on either channel.
//   A command accepted into the input register is executed once the response register
//   is free or being emptied, and its result is then held in the response register.
//   Throughput: one command per cycle while rsp_stall is low; input and response
//   registers form two stages, so a new command is taken while a response still waits.
//   When rsp_stall is held, the response holds, one further command parks in the
//   input register, and req_stall rises until the response is taken.
//   csr_we writes speed_limit_percent (index 0) or direction_pause_ms (index 1);
//   write only while no command is in flight.
//   Reset (synchronous) empties both stages, returns the machine to off with default
//   configuration; the ramp table is not cleared and must be loaded before stepping.
module stepper_ramp_move_controller_top #(
   parameter int TABLE_LENGTH = srmc_pkg::TABLE_LENGTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_cmd,
   input  logic signed [15:0]                 req_step_count,
   input  logic [5:0]                         req_table_slot,
   input  logic [15:0]                        req_table_word,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_machine_state,
   output logic                               rsp_sleep_level,
   output logic                               rsp_microstep_level,
   output logic                               rsp_direction_level,
   output logic                               rsp_step_pulse,
   output logic [15:0]                        rsp_timer_period,
   output logic [5:0]                         rsp_speed_index,
   output logic                               rsp_stopped,
   output logic [31:0]                        rsp_steps_this_move,
   // configuration write port
   input  logic                               csr_we,
   input  logic [srmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [srmc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import srmc_pkg::*;
   `include "assert_macros.svh"

   localparam int PW = $clog2(TABLE_LENGTH);
   localparam logic [PW-1:0] CAP_RESET = PW'(cap_calc(SPEED_LIMIT_RESET, TABLE_LENGTH - 1));

   logic               in_valid_ff;
   logic [2:0]         in_cmd_ff;
   logic signed [15:0] in_steps_ff;
   logic [5:0]         in_slot_ff;
   logic [15:0]        in_word_ff;
   logic               fire;
   logic               accept;

   logic               rsp_valid_ff;
   result_type         rsp_ff;
   logic               period_sel_ff;

   logic [PW-1:0]      cap_ff;
   logic [15:0]        pause_ff;

   result_type         result;
   logic               ram_we;
   logic [PW-1:0]      ram_waddr;
   logic [15:0]        ram_wdata;
   logic               ram_re;
   logic [PW-1:0]      ram_raddr;
   logic [15:0]        ram_rdata;

   // Handshake: execute when the response register is free or being emptied
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff   <= req_cmd;
         in_steps_ff <= req_step_count;
         in_slot_ff  <= req_table_slot;
         in_word_ff  <= req_table_word;
      end
   end

   // Configuration registers; the speed cap is kept as a ramp index
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         pause_ff <= DIR_PAUSE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPEED_LIMIT: cap_ff   <= PW'(cap_calc(csr_wdata[6:0], TABLE_LENGTH - 1));
            CSR_DIR_PAUSE:   pause_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   srmc_core #(
      .TABLE_LENGTH (TABLE_LENGTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .cmd        (cmd_type'(in_cmd_ff)),
      .step_count (in_steps_ff),
      .table_slot (in_slot_ff),
      .table_word (in_word_ff),
      .cap        (cap_ff),
      .pause_ms   (pause_ff),
      .result     (result),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr)
   );

   srmc_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_LENGTH)
   ) u_ramp_ram (
      .clock (clock),
      .we    (ram_we && fire),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re && fire),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         period_sel_ff <= 1'b0;
      end else begin
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fire && result.step_pulse) begin
            period_sel_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_machine_state   = rsp_ff.machine_state;
   assign rsp_sleep_level     = rsp_ff.sleep_level;
   assign rsp_microstep_level = rsp_ff.microstep_level;
   assign rsp_direction_level = rsp_ff.direction_level;
   assign rsp_step_pulse      = rsp_ff.step_pulse;
   assign rsp_speed_index     = rsp_ff.speed_index;
   assign rsp_stopped         = rsp_ff.stopped;
   assign rsp_steps_this_move = rsp_ff.steps_this_move;
   // RAM read data only changes on a step pulse, in step with the response register
   assign rsp_timer_period    = period_sel_ff ? ram_rdata : PERIOD_RESET;

   // Reset always empties the response stage
   `SRMC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid_ff, "response valid after reset")
   // A pulse always switches the period over to the ramp table
   `SRMC_ASSERT(a_period_sel, clock, reset, fire && result.step_pulse |=> period_sel_ff && rsp_step_pulse, "step pulse did not select ramp period")

endmodule

// File: hdl/srmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read, holds between reads
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/srmc_core.sv
// Control machine, step counters and ramp index of the stepper ramp controller.
// Depends on srmc_pkg and assert_macros.svh; drives the ramp RAM ports.
module srmc_core #(
   parameter int TABLE_LENGTH = srmc_pkg::TABLE_LENGTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  srmc_pkg::cmd_type               cmd,
   input  logic signed [15:0]              step_count,
   input  logic [5:0]                      table_slot,
   input  logic [15:0]                     table_word,
   input  logic [$clog2(TABLE_LENGTH)-1:0] cap,
   input  logic [15:0]                     pause_ms,
   output srmc_pkg::result_type            result,
   output logic                            ram_we,
   output logic [$clog2(TABLE_LENGTH)-1:0] ram_waddr,
   output logic [15:0]                     ram_wdata,
   output logic                            ram_re,
   output logic [$clog2(TABLE_LENGTH)-1:0] ram_raddr
);
   import srmc_pkg::*;
   `include "assert_macros.svh"

   localparam int PW = $clog2(TABLE_LENGTH);

   state_type          ctrl_ff, ctrl_in;
   state_type          prior_ff, prior_in;
   state_type          resume_ff, resume_in;
   event_type          pend_ff, pend_in;
   logic signed [15:0] req_ff, req_in;
   logic               fwd_ff, fwd_in;
   logic               dir_ff, dir_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        taken_ff, taken_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [15:0]        wait_ff, wait_in;
   logic               sleep_ff, sleep_in;
   logic               micro_ff, micro_in;

   logic               pulse;
   logic               want_fwd;
   logic [16:0]        move_mag;
   logic [32:0]        ext_sum;
   logic [15:0]        wait_cur;
   state_type          resume_cur;
   logic [31:0]        rem_dec;
   logic [31:0]        taken_inc;
   logic               stopped;

   // Next state for one command word
   always_comb begin
      ctrl_in    = ctrl_ff;
      prior_in   = prior_ff;
      resume_in  = resume_ff;
      pend_in    = pend_ff;
      req_in     = req_ff;
      fwd_in     = fwd_ff;
      dir_in     = dir_ff;
      rem_in     = rem_ff;
      taken_in   = taken_ff;
      pos_in     = pos_ff;
      wait_in    = wait_ff;
      sleep_in   = sleep_ff;
      micro_in   = micro_ff;
      pulse      = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      want_fwd   = ~req_ff[15];
      move_mag   = req_ff[15] ? (17'd0 - {1'b1, req_ff}) : {1'b0, req_ff};
      ext_sum    = {1'b0, rem_ff} + (req_ff[15] ? 33'd0 : 33'({1'b0, req_ff}));
      wait_cur   = wait_ff;
      resume_cur = resume_ff;
      rem_dec    = rem_ff - 32'd1;
      taken_inc  = (taken_ff == 32'hFFFF_FFFF) ? taken_ff : taken_ff + 32'd1;

      case (cmd)
         CMD_POLL: begin
            case (ctrl_ff)
               ST_OFF: begin
                  if (prior_ff != ST_OFF) begin
                     sleep_in = 1'b0;
                     prior_in = ST_OFF;
                  end
                  if (pend_ff == EV_MOVE || pend_ff == EV_EXTEND) begin
                     ctrl_in  = ST_RUN;
                     sleep_in = 1'b1;
                     micro_in = 1'b1;
                  end
               end
               ST_RUN: begin
                  prior_in = ST_RUN;
                  case (pend_ff)
                     EV_MOVE: begin
                        if (want_fwd != fwd_ff) begin
                           // direction change only once the last move is done
                           if (rem_ff == 32'd0) begin
                              ctrl_in = ST_WAIT;
                              fwd_in  = want_fwd;
                              dir_in  = want_fwd;
                           end
                        end else begin
                           rem_in   = 32'(move_mag);
                           taken_in = 32'd0;
                           req_in   = 16'sd0;
                           pend_in  = EV_NONE;
                        end
                     end
                     EV_EXTEND: begin
                        rem_in  = ext_sum[32] ? 32'hFFFF_FFFF : ext_sum[31:0];
                        req_in  = 16'sd0;
                        pend_in = EV_NONE;
                     end
                     EV_OFF: begin
                        if (rem_ff == 32'd0) begin
                           ctrl_in = ST_OFF;
                           pend_in = EV_NONE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               ST_WAIT: begin
                  // first poll in the wait restarts the pause count
                  if (prior_ff != ST_WAIT) begin
                     wait_cur   = 16'd0;
                     resume_cur = prior_ff;
                     prior_in   = ST_WAIT;
                  end
                  wait_in   = wait_cur;
                  resume_in = resume_cur;
                  if (wait_cur > pause_ms) begin
                     ctrl_in = resume_cur;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_MOVE: begin
            req_in  = step_count;
            pend_in = EV_MOVE;
         end
         CMD_EXTEND: begin
            // magnitude, most negative count saturates
            if (step_count == -16'sd32768) begin
               req_in = 16'sd32767;
            end else if (step_count < 16'sd0) begin
               req_in = -step_count;
            end else begin
               req_in = step_count;
            end
            pend_in = EV_EXTEND;
         end
         CMD_STOP, CMD_TURN_OFF: begin
            if (rem_ff > 32'(cap)) begin
               rem_in = 32'(cap);
            end
            pend_in = (cmd == CMD_TURN_OFF) ? EV_OFF : EV_NONE;
         end
         CMD_STEP: begin
            if (rem_ff != 32'd0) begin
               pulse    = 1'b1;
               taken_in = taken_inc;
               rem_in   = rem_dec;
               // accelerate under the cap, decelerate near the end
               if (rem_dec > 32'(pos_ff) && pos_ff < cap) begin
                  pos_in = pos_ff + 1'b1;
               end else if (rem_dec < 32'(pos_ff) && taken_inc > rem_dec &&
                            pos_ff != '0) begin
                  pos_in = pos_ff - 1'b1;
               end
               ram_re = 1'b1;
            end
         end
         CMD_MS_TICK: begin
            if (ctrl_ff == ST_WAIT && prior_ff == ST_WAIT && wait_ff != 16'hFFFF) begin
               wait_in = wait_ff + 16'd1;
            end
         end
         CMD_LOAD: begin
            if (32'(table_slot) < TABLE_LENGTH) begin
               ram_we = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_waddr = PW'(table_slot);
   assign ram_wdata = table_word;
   assign ram_raddr = pos_in;

   // Result fields from the updated state
   assign stopped = (req_in == 16'sd0) && (rem_in == 32'd0);

   always_comb begin
      result.machine_state   = ctrl_in;
      result.sleep_level     = sleep_in;
      result.microstep_level = micro_in;
      result.direction_level = dir_in;
      result.step_pulse      = pulse;
      result.speed_index     = 6'(pos_in);
      result.stopped         = stopped;
      result.steps_this_move = stopped ? 32'd0 : taken_in;
   end

   // State registers, advanced once per executed word
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= ST_OFF;
         prior_ff  <= ST_OFF;
         resume_ff <= ST_OFF;
         pend_ff   <= EV_NONE;
         req_ff    <= 16'sd0;
         fwd_ff    <= 1'b1;
         dir_ff    <= 1'b0;
         rem_ff    <= 32'd0;
         taken_ff  <= 32'd0;
         pos_ff    <= '0;
         wait_ff   <= 16'd0;
         sleep_ff  <= 1'b0;
         micro_ff  <= 1'b0;
      end else if (fire) begin
         ctrl_ff   <= ctrl_in;
         prior_ff  <= prior_in;
         resume_ff <= resume_in;
         pend_ff   <= pend_in;
         req_ff    <= req_in;
         fwd_ff    <= fwd_in;
         dir_ff    <= dir_in;
         rem_ff    <= rem_in;
         taken_ff  <= taken_in;
         pos_ff    <= pos_in;
         wait_ff   <= wait_in;
         sleep_ff  <= sleep_in;
         micro_ff  <= micro_in;
      end
   end

   // A step pulse consumes exactly one remaining step
   `SRMC_ASSERT(a_step_dec, clock, reset, fire && cmd == CMD_STEP && rem_ff != 32'd0 |=> rem_ff == $past(rem_ff) - 32'd1, "step tick did not consume one step")
   // The ramp index stays inside the table
   `SRMC_ASSERT(a_pos_range, clock, reset, 32'(pos_ff) <= TABLE_LENGTH - 1, "ramp index beyond table")

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for stepper_ramp_move_controller_top: random command words with
// a word-level predictor of the move machine. Depends on srmc_pkg and the top RTL only.
module tb;
   import srmc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RAMP_TOP    = TABLE_LENGTH_DEFAULT - 1;

   // One command word and one response word
   typedef struct packed {
      cmd_type            cmd;
      logic signed [15:0] steps;
      logic [5:0]         slot;
      logic [15:0]        word;
   } cmd_word_type;

   typedef struct packed {
      state_type   mstate;
      logic        sleep;
      logic        micro;
      logic        dir;
      logic        pulse;
      logic [15:0] period;
      logic [5:0]  index;
      logic        stopped;
      logic [31:0] steps;
   } status_word_type;

   // DUT connections, inputs all driven from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_cmd = '0;
   logic signed [15:0] req_step_count = '0;
   logic [5:0]         req_table_slot = '0;
   logic [15:0]        req_table_word = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_machine_state;
   logic               rsp_sleep_level;
   logic               rsp_microstep_level;
   logic               rsp_direction_level;
   logic               rsp_step_pulse;
   logic [15:0]        rsp_timer_period;
   logic [5:0]         rsp_speed_index;
   logic               rsp_stopped;
   logic [31:0]        rsp_steps_this_move;
   logic               csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   stepper_ramp_move_controller_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_step_count      (req_step_count),
      .req_table_slot      (req_table_slot),
      .req_table_word      (req_table_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_machine_state   (rsp_machine_state),
      .rsp_sleep_level     (rsp_sleep_level),
      .rsp_microstep_level (rsp_microstep_level),
      .rsp_direction_level (rsp_direction_level),
      .rsp_step_pulse      (rsp_step_pulse),
      .rsp_timer_period    (rsp_timer_period),
      .rsp_speed_index     (rsp_speed_index),
      .rsp_stopped         (rsp_stopped),
      .rsp_steps_this_move (rsp_steps_this_move),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Bench bookkeeping
   cmd_word_type    cmd_q[$];
   status_word_type status_q[$];
   cmd_word_type    cur_word;
   int         n_queued = 0;
   int         n_accepted = 0;
   int         n_checked = 0;
   int         n_errors = 0;
   int         n_settings = 0;
   int         cycle_count = 0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;
   logic       hold_on = 1'b0;
   bit         calm = 1'b0;

   // Predictor state and its copy of the registers
   logic [6:0]  limit_pct;
   logic [15:0] pause_ms;
   state_type   mc_state, mc_prev, mc_resume;
   event_type   mc_event;
   int          req_steps;
   logic        fwd, dir_out, sleep_out, micro_out;
   logic [31:0] remaining, taken;
   logic [5:0]  ramp_pos;
   logic [15:0] pause_count, period;
   logic [15:0] ramp_mem [TABLE_LENGTH_DEFAULT];

   function automatic void reset_model();
      limit_pct   = SPEED_LIMIT_RESET;
      pause_ms    = DIR_PAUSE_RESET;
      mc_state    = ST_OFF;
      mc_prev     = ST_OFF;
      mc_resume   = ST_OFF;
      mc_event    = EV_NONE;
      req_steps   = 0;
      fwd         = 1'b1;
      dir_out     = 1'b0;
      sleep_out   = 1'b0;
      micro_out   = 1'b0;
      remaining   = '0;
      taken       = '0;
      ramp_pos    = '0;
      pause_count = '0;
      period      = PERIOD_RESET;
   endfunction

   // Ramp index ceiling from the speed limit, saturated at the table top
   function automatic int unsigned ramp_cap();
      int unsigned c;
      c = int'(limit_pct) * RAMP_TOP / 100;
      if (c > RAMP_TOP) begin
         c = RAMP_TOP;
      end
      return c;
   endfunction

   // One pass of the off / running / waiting machine
   function automatic void poll_pass();
      logic        want_fwd;
      int unsigned add;
      case (mc_state)
         ST_OFF: begin
            if (mc_prev != ST_OFF) begin
               sleep_out = 1'b0;
               mc_prev   = ST_OFF;
            end
            if (mc_event == EV_MOVE || mc_event == EV_EXTEND) begin
               mc_state  = ST_RUN;
               sleep_out = 1'b1;
               micro_out = 1'b1;
            end
         end
         ST_RUN: begin
            mc_prev = ST_RUN;
            case (mc_event)
               EV_MOVE: begin
                  want_fwd = (req_steps >= 0);
                  if (want_fwd != fwd) begin
                     // direction change only once the current move has run out
                     if (remaining == 0) begin
                        mc_state = ST_WAIT;
                        fwd      = want_fwd;
                        dir_out  = want_fwd;
                     end
                  end else begin
                     remaining = (req_steps >= 0) ? 32'(req_steps) : 32'(-req_steps);
                     taken     = '0;
                     req_steps = 0;
                     mc_event  = EV_NONE;
                  end
               end
               EV_EXTEND: begin
                  add = (req_steps < 0) ? 0 : req_steps;
                  remaining = (remaining > 32'hFFFF_FFFF - add) ? 32'hFFFF_FFFF
                                                                 : remaining + add;
                  req_steps = 0;
                  mc_event  = EV_NONE;
               end
               EV_OFF: begin
                  if (remaining == 0) begin
                     mc_state = ST_OFF;
                     mc_event = EV_NONE;
                  end
               end
               default: ;
            endcase
         end
         ST_WAIT: begin
            if (mc_prev != ST_WAIT) begin
               pause_count = '0;
               mc_resume   = mc_prev;
               mc_prev     = ST_WAIT;
            end
            if (pause_count > pause_ms) begin
               mc_state = mc_resume;
            end
         end
         default: ;
      endcase
   endfunction

   // Step tick: pulse, count, walk the ramp, load the period
   function automatic logic step_once();
      int unsigned cap;
      if (remaining == 0) begin
         return 1'b0;
      end
      if (taken != 32'hFFFF_FFFF) begin
         taken++;
      end
      remaining--;
      cap = ramp_cap();
      if (remaining > ramp_pos && ramp_pos < cap) begin
         ramp_pos++;
      end else if (remaining < ramp_pos && taken > remaining && ramp_pos > 0) begin
         ramp_pos--;
      end
      period = ramp_mem[ramp_pos];
      return 1'b1;
   endfunction

   // Apply one command word and form the status it must produce
   function automatic status_word_type next_status(input cmd_word_type it);
      status_word_type sw;
      logic        pulse;
      int          mag;
      int unsigned cap;
      pulse = 1'b0;
      case (it.cmd)
         CMD_POLL: poll_pass();
         CMD_MOVE: begin
            req_steps = $signed(it.steps);
            mc_event  = EV_MOVE;
         end
         CMD_EXTEND: begin
            mag = $signed(it.steps);
            if (mag < 0) begin
               mag = -mag;
            end
            if (mag > 32767) begin
               mag = 32767;
            end
            req_steps = mag;
            mc_event  = EV_EXTEND;
         end
         CMD_STOP, CMD_TURN_OFF: begin
            cap = ramp_cap();
            if (remaining > cap) begin
               remaining = cap;
            end
            mc_event = (it.cmd == CMD_TURN_OFF) ? EV_OFF : EV_NONE;
         end
         CMD_STEP: pulse = step_once();
         CMD_MS_TICK: begin
            if (mc_state == ST_WAIT && mc_prev == ST_WAIT && pause_count != 16'hFFFF) begin
               pause_count++;
            end
         end
         default: ramp_mem[it.slot] = it.word;
      endcase
      sw.mstate  = mc_state;
      sw.sleep   = sleep_out;
      sw.micro   = micro_out;
      sw.dir     = dir_out;
      sw.pulse   = pulse;
      sw.period  = period;
      sw.index   = ramp_pos;
      sw.stopped = (req_steps == 0 && remaining == 0);
      sw.steps   = sw.stopped ? 32'd0 : taken;
      return sw;
   endfunction

   // Stimulus helpers
   task automatic queue_word(input cmd_type c, input logic [15:0] s, input logic [5:0] sl,
                             input logic [15:0] w);
      cmd_word_type it;
      it.cmd   = c;
      it.steps = s;
      it.slot  = sl;
      it.word  = w;
      cmd_q.push_back(it);
      n_queued++;
   endtask

   task automatic queue_cmd(input cmd_type c, input int s);
      queue_word(c, 16'(s), 6'($urandom), 16'($urandom));
   endtask

   // Well-formed move: request, start, optional pause ticks, then step ticks mixed with polls
   task automatic queue_move_seq(output int count);
      int n, mag, k;
      n   = $urandom_range(0, 80) - 40;
      mag = (n < 0) ? -n : n;
      count = 0;
      queue_cmd(CMD_MOVE, n);
      repeat (3) queue_cmd(CMD_POLL, $urandom);
      count += 4;
      k = $urandom_range(0, 6);
      repeat (k) begin
         queue_cmd(CMD_MS_TICK, $urandom);
         queue_cmd(CMD_POLL, $urandom);
      end
      queue_cmd(CMD_POLL, $urandom);
      count += 2 * k + 1;
      repeat (mag + 2) begin
         queue_cmd(($urandom_range(0, 7) == 0) ? CMD_POLL : CMD_STEP, $urandom);
      end
      count += mag + 2;
   endtask

   task automatic queue_random(input int n_items);
      int done, seq_len, r, s;
      cmd_type c;
      done = 0;
      while (done < n_items) begin
         if ($urandom_range(0, 3) == 0) begin
            queue_move_seq(seq_len);
            done += seq_len;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 25) c = CMD_POLL;
            else if (r < 55) c = CMD_STEP;
            else if (r < 68) c = CMD_MS_TICK;
            else if (r < 78) c = CMD_MOVE;
            else if (r < 84) c = CMD_EXTEND;
            else if (r < 88) c = CMD_STOP;
            else if (r < 92) c = CMD_TURN_OFF;
            else c = CMD_LOAD;
            s = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 80) - 40;
            queue_cmd(c, s);
            done++;
         end
      end
   endtask

   // Sender pause: everything accepted and answered, then let the pipe settle
   task automatic drain();
      while (!(cmd_q.size() == 0 && n_accepted == n_queued && n_checked == n_accepted)) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic set_config(input int unsigned pct, input int unsigned pause);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SPEED_LIMIT;
      csr_wdata <= 16'(pct);
      @(posedge clock);
      csr_index <= CSR_DIR_PAUSE;
      csr_wdata <= 16'(pause);
      @(posedge clock);
      csr_we <= 1'b0;
      limit_pct = 7'(pct);
      pause_ms  = 16'(pause);
      n_settings++;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         n_errors++;
      end
   endtask

   // Driver: present queued command words, with random idle bursts outside the calm stretch
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            status_q.push_back(next_status(cur_word));
            n_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
               cur_word = cmd_q.pop_front();
               req_cmd        <= cur_word.cmd;
               req_step_count <= cur_word.steps;
               req_table_slot <= cur_word.slot;
               req_table_word <= cur_word.word;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long hold-off of the response side while the sender still has words queued
   always @(posedge clock) begin
      if (reset) begin
         hold_on <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         hold_on <= 1'b1;
      end else if (!hold_done && n_checked >= 300 && cmd_q.size() > 16) begin
         hold_done = 1'b1;
         hold_left = 47;
         hold_on <= 1'b1;
      end else begin
         hold_on <= 1'b0;
      end
   end

   // Monitor: check each response word, stall at random
   always @(posedge clock) begin : rsp_monitor
      status_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               $error("response word with no command outstanding");
               n_errors++;
            end else begin
               want = status_q.pop_front();
               check_field("machine_state", want.mstate, rsp_machine_state);
               check_field("sleep_level", want.sleep, rsp_sleep_level);
               check_field("microstep_level", want.micro, rsp_microstep_level);
               check_field("direction_level", want.dir, rsp_direction_level);
               check_field("step_pulse", want.pulse, rsp_step_pulse);
               check_field("timer_period", want.period, rsp_timer_period);
               check_field("speed_index", want.index, rsp_speed_index);
               check_field("stopped", want.stopped, rsp_stopped);
               check_field("steps_this_move", want.steps, rsp_steps_this_move);
               n_checked++;
            end
         end
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stepper_ramp_move_controller_top test failed");
         $finish;
      end
   end

   // Sequence of phases
   initial begin
      int k;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // fill the whole ramp table first so no step tick reads an empty entry
      for (k = 0; k < TABLE_LENGTH_DEFAULT; k++) begin
         queue_word(CMD_LOAD, 16'($urandom), 6'(k),
                    (k == 0) ? 16'h0000 : (k == RAMP_TOP) ? 16'hFFFF : 16'($urandom));
      end

      // directed: idle commands while off, extremes of step counts, saturating extend
      queue_cmd(CMD_POLL, 0);
      queue_cmd(CMD_STEP, 0);
      queue_cmd(CMD_MS_TICK, 0);
      queue_cmd(CMD_STOP, 0);
      queue_cmd(CMD_MOVE, 32767);
      queue_cmd(CMD_POLL, 0);
      queue_cmd(CMD_POLL, 0);
      queue_cmd(CMD_STEP, 0);
      queue_cmd(CMD_STEP, 0);
      queue_cmd(CMD_EXTEND, -32768);
      queue_cmd(CMD_POLL, 0);
      queue_cmd(CMD_STOP, 0);
      queue_cmd(CMD_STEP, 0);
      queue_cmd(CMD_MOVE, -32768);
      queue_cmd(CMD_POLL, 0);
      queue_cmd(CMD_TURN_OFF, 0);
      queue_cmd(CMD_POLL, 0);
      queue_cmd(CMD_MOVE, 0);
      queue_cmd(CMD_EXTEND, -1);
      queue_cmd(CMD_POLL, 0);
      queue_word(CMD_LOAD, 16'hFFFF, 6'd63, 16'hFFFF);
      queue_cmd(CMD_POLL, 0);
      drain();

      // random phases across register settings, extremes included
      set_config(100, 0);
      queue_random(90);
      drain();
      set_config(0, 3);
      queue_random(90);
      drain();
      set_config(127, 1);
      queue_random(90);
      drain();
      set_config(50, 65535);
      queue_random(90);
      drain();
      set_config($urandom_range(0, 127), $urandom_range(0, 65535));
      queue_random(90);
      drain();
      set_config($urandom_range(0, 127), $urandom_range(0, 6));
      queue_random(90);
      drain();

      // last stretch with no idling on either side
      calm = 1'b1;
      set_config(100, 2);
      queue_random(70);
      drain();
      repeat (8) @(posedge clock);

      if (status_q.size() != 0) begin
         $error("%0d expected response words never arrived", status_q.size());
         n_errors++;
      end
      $display("Checked %0d response words over %0d register settings,", n_checked,
               n_settings);
      $display("with idle bursts on both channels and one long response hold-off.");
      if (n_errors == 0) begin
         $display("stepper_ramp_move_controller_top test passed");
      end else begin
         $display("stepper_ramp_move_controller_top test failed");
      end
      $finish;
   end

endmodule

// File: stepper_ramp_move_controller_top.f
+incdir+hdl
hdl/srmc_pkg.sv
hdl/srmc_ram.sv
hdl/srmc_core.sv
hdl/stepper_ramp_move_controller_top.sv
bench/tb.sv
